// ===== rtl/cvtsp_pkg.sv =====
// Shared types and constants for the triggered sample player.
// Holds command codes, note-window table, lane and memory-control types.
// No dependencies.
package cvtsp_pkg;

  // Voices are fixed by the port layout: one control voltage and one audio word each.
  localparam int NUM_VOICES = 2;
  localparam int LANE_W     = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

  localparam int CV_W       = 16;
  localparam int AUDIO_W    = 16;
  localparam int SLOT_W     = 4;
  localparam int LADDR_W    = 16;
  localparam int LSAMPLE_W  = 16;
  localparam int LLEN_W     = 17;
  localparam int CMD_W      = 2;
  localparam int MAX_SLOTS  = 15;

  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = NUM_VOICES * AUDIO_W;

  localparam logic [SLOT_W-1:0] NO_SLOT = 4'd15;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK      = 2'd0,
    CMD_WR_SAMPLE = 2'd1,
    CMD_WR_LENGTH = 2'd2
  } cmd_t;

  // Note centres near k/12 V in Q4.12, window of +/-82 LSB inclusive.
  localparam logic signed [CV_W-1:0] CV_WINDOW = 16'sd82;
  localparam logic signed [CV_W-1:0] NOTE_CENTRE [MAX_SLOTS] = '{
    16'sd328,  16'sd696,  16'sd1024, 16'sd1352, 16'sd1720,
    16'sd2048, 16'sd2376, 16'sd2744, 16'sd3072, 16'sd3400,
    16'sd3768, 16'sd4096, 16'sd4424, 16'sd4792, 16'sd5120
  };

  // Control of the single sample-memory port for one cycle.
  typedef struct packed {
    logic              we;
    logic              re;
    logic [LANE_W-1:0] lane;
    logic              play;
  } mem_ctl_t;

endpackage

// ===== rtl/cvtsp_match.sv =====
// Note-window matcher of one voice lane: lowest matching slot wins.
// Depends on cvtsp_pkg (note table, widths, NO_SLOT).
module cvtsp_match import cvtsp_pkg::*; #(
  parameter int NUM_SLOTS = 12
) (
  input  logic signed [CV_W-1:0]   cv,
  output logic                     hit,
  output logic        [SLOT_W-1:0] slot
);

  always_comb begin
    hit  = 1'b0;
    slot = NO_SLOT;
    // walk downward so the lowest matching centre is the one left standing
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (cv >= NOTE_CENTRE[i] - CV_WINDOW && cv <= NOTE_CENTRE[i] + CV_WINDOW) begin
        hit  = 1'b1;
        slot = SLOT_W'(i);
      end
    end
  end

endmodule

// ===== rtl/cvtsp_voice.sv =====
// Playback state of one voice lane: active slot and read pointer.
// Depends on cvtsp_pkg (widths, NO_SLOT).
module cvtsp_voice import cvtsp_pkg::*; #(
  parameter int SLOT_DEPTH = 65536,
  parameter int ADDR_W     = 20,
  parameter int LEN_W      = 17
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic              hit,
  input  logic [SLOT_W-1:0] slot,
  input  logic [LEN_W-1:0]  len,
  output logic              play,
  output logic [ADDR_W-1:0] addr
);

  logic [SLOT_W-1:0] active_r, active_nxt;
  logic [LEN_W-1:0]  ptr_r, ptr_nxt;
  logic [LEN_W-1:0]  ptr0;

  always_comb begin
    // restart the pointer on a new slot
    ptr0 = (active_r != slot) ? '0 : ptr_r;
    play = hit && (ptr0 < len);
    addr = play ? ADDR_W'(slot) * ADDR_W'(SLOT_DEPTH) + ADDR_W'(ptr0) : '0;
    if (!hit) begin
      active_nxt = NO_SLOT;
      ptr_nxt    = '0;
    end else begin
      active_nxt = slot;
      ptr_nxt    = play ? ptr0 + LEN_W'(1) : ptr0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= NO_SLOT;
      ptr_r    <= '0;
    end else if (step) begin
      active_r <= active_nxt;
      ptr_r    <= ptr_nxt;
    end
  end

endmodule

// ===== rtl/cvtsp_store.sv =====
// Sample memory with one shared port, read-data register and the lane merge
// that assembles one output word per tick. Depends on cvtsp_pkg (mem_ctl_t, widths).
module cvtsp_store import cvtsp_pkg::*; #(
  parameter int DEPTH       = 786432,
  parameter int ADDR_W      = 20,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  mem_ctl_t               ctl,
  input  logic [ADDR_W-1:0]      addr,
  input  logic [SAMPLE_BITS-1:0] wdata,
  output logic                   rd_free,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata    // audio_a[15:0], audio_b[31:16]
);

  localparam logic [LANE_W-1:0] LAST_LANE = LANE_W'(NUM_VOICES - 1);

  logic [SAMPLE_BITS-1:0] mem [DEPTH];
  logic [SAMPLE_BITS-1:0] rd_data_r;
  logic                   rdv_r;
  logic [LANE_W-1:0]      rd_lane_r;
  logic                   rd_play_r;
  logic [AUDIO_W-1:0]     hold_r [NUM_VOICES];
  logic                   out_v_r;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic [SAMPLE_BITS+AUDIO_W-1:0] rd_ext;
  logic [AUDIO_W-1:0]             rd_audio;
  logic                           out_free;
  logic                           rd_take;
  logic                           rd_last;

  always_comb begin
    rd_ext   = {AUDIO_W'(0), rd_data_r};
    rd_audio = rd_play_r ? rd_ext[AUDIO_W-1:0] : '0;
    out_free = !out_v_r || out_tready;
    rd_last  = (rd_lane_r == LAST_LANE);
    // earlier lanes park in hold registers; the last lane needs room at the output
    rd_take  = rdv_r && (!rd_last || out_free);
    rd_free  = !rdv_r || rd_take;
    for (int v = 0; v < NUM_VOICES; v++) begin
      out_data_nxt[v*AUDIO_W +: AUDIO_W] = hold_r[v];
    end
    out_data_nxt[(NUM_VOICES-1)*AUDIO_W +: AUDIO_W] = rd_audio;
  end

  // single port: a write wins, a read loads the data register
  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[addr] <= wdata;
    end else if (ctl.re) begin
      rd_data_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.re) begin
      rd_lane_r <= ctl.lane;
      rd_play_r <= ctl.play;
    end
    if (rd_take && !rd_last) begin
      hold_r[rd_lane_r] <= rd_audio;
    end
    if (rd_take && rd_last) begin
      out_data_r <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rdv_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (ctl.re) begin
        rdv_r <= 1'b1;
      end else if (rd_take) begin
        rdv_r <= 1'b0;
      end
      if (rd_take && rd_last) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== rtl/cv_triggered_sample_player_unit.sv =====
// Top level of the two-voice triggered sample player.
// Depends on cvtsp_pkg, cvtsp_match, cvtsp_voice and cvtsp_store.
//
// Each tick word on the input carries one control voltage per voice; every voice
// matches its voltage against the note windows, picks a sample slot and plays the
// slot's stored words one per tick until the slot length is reached, then silence.
// Load words write sample words and slot lengths in order with the ticks. A tick
// occupies the single-port sample memory for one read per voice, lanes in turn,
// while a load word takes at most one access; the match and evaluate registers
// can hold the words behind it meanwhile. A tick's result passes the input
// register, match, evaluate, the memory reads and the output register. The
// memories need no clearing pass: a sample or length must be written before a
// tick reads it, otherwise that voice's output is undefined. Payload words are
// accepted while a result still waits at the output register.
module cv_triggered_sample_player_unit import cvtsp_pkg::*; #(
  parameter int NUM_SLOTS   = 12,
  parameter int SLOT_DEPTH  = 65536,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // voice_cv_a[15:0], voice_cv_b[31:16], load_slot[35:32], load_address[51:36],
  // load_sample[67:52], load_length[84:68], zero pad[87:85]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [CMD_W-1:0]       in_tuser,    // cmd[1:0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata    // audio_a[15:0], audio_b[31:16]
);

  localparam int DEPTH  = NUM_SLOTS * SLOT_DEPTH;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int LEN_W  = $clog2(SLOT_DEPTH + 1);
  localparam int SIDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [LANE_W-1:0] LAST_LANE = LANE_W'(NUM_VOICES - 1);

  // ---------------------------------------------------------------------------
  // Match stage: input register, note matching per lane, length lookup
  // ---------------------------------------------------------------------------
  logic                        m_v_r;
  cmd_t                        m_cmd_r;
  logic signed [CV_W-1:0]      m_cv_r [NUM_VOICES];
  logic [SLOT_W-1:0]           m_lslot_r;
  logic [LADDR_W-1:0]          m_laddr_r;
  logic [LSAMPLE_W-1:0]        m_lsample_r;
  logic [LLEN_W-1:0]           m_llen_r;

  logic                        lane_hit  [NUM_VOICES];
  logic [SLOT_W-1:0]           lane_slot [NUM_VOICES];
  logic [LEN_W-1:0]            len_sat;
  logic [LEN_W-1:0]            slot_len_mem [NUM_SLOTS];

  // ---------------------------------------------------------------------------
  // Evaluate stage: voice state update, address generation
  // ---------------------------------------------------------------------------
  logic                        e_v_r;
  cmd_t                        e_cmd_r;
  logic                        e_hit_r  [NUM_VOICES];
  logic [SLOT_W-1:0]           e_slot_r [NUM_VOICES];
  logic [LEN_W-1:0]            e_len_r  [NUM_VOICES];
  logic [SLOT_W-1:0]           e_lslot_r;
  logic [LADDR_W-1:0]          e_laddr_r;
  logic [LSAMPLE_W-1:0]        e_lsample_r;

  logic                        lane_play [NUM_VOICES];
  logic [ADDR_W-1:0]           lane_addr [NUM_VOICES];
  logic                        e_wen;
  logic [ADDR_W-1:0]           e_waddr;
  logic [SAMPLE_BITS+LSAMPLE_W-1:0] e_wext;

  // ---------------------------------------------------------------------------
  // Memory stage: one access per cycle unless the read path is full, lanes in turn for a tick
  // ---------------------------------------------------------------------------
  logic                        s_v_r;
  logic                        s_tick_r;
  logic [LANE_W-1:0]           s_ph_r;
  logic                        s_play_r [NUM_VOICES];
  logic [ADDR_W-1:0]           s_addr_r [NUM_VOICES];
  logic                        s_wen_r;
  logic [ADDR_W-1:0]           s_waddr_r;
  logic [SAMPLE_BITS-1:0]      s_wdata_r;

  mem_ctl_t                    mem_ctl;
  logic [ADDR_W-1:0]           mem_addr;
  logic                        rd_free;

  logic s_done, s_free, e_move, e_free, m_move, m_free, accept, voice_step;

  // Stall chain: each stage moves on when the one after it frees up.
  always_comb begin
    s_done     = s_v_r && (!s_tick_r || (rd_free && s_ph_r == LAST_LANE));
    s_free     = !s_v_r || s_done;
    e_move     = e_v_r && s_free;
    e_free     = !e_v_r || s_free;
    m_move     = m_v_r && e_free;
    m_free     = !m_v_r || e_free;
    accept     = in_tvalid && m_free;
    voice_step = e_move && (e_cmd_r == CMD_TICK);
  end

  assign in_tready = m_free;

  // Match stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
    end else if (m_free) begin
      m_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_cmd_r     <= cmd_t'(in_tuser);
      m_cv_r[0]   <= in_tdata[15:0];
      m_cv_r[1]   <= in_tdata[31:16];
      m_lslot_r   <= in_tdata[35:32];
      m_laddr_r   <= in_tdata[51:36];
      m_lsample_r <= in_tdata[67:52];
      m_llen_r    <= in_tdata[84:68];
    end
  end

  // One matcher and one voice per lane.
  for (genvar v = 0; v < NUM_VOICES; v++) begin : g_lane
    cvtsp_match #(
      .NUM_SLOTS (NUM_SLOTS)
    ) u_match (
      .cv   (m_cv_r[v]),
      .hit  (lane_hit[v]),
      .slot (lane_slot[v])
    );

    cvtsp_voice #(
      .SLOT_DEPTH (SLOT_DEPTH),
      .ADDR_W     (ADDR_W),
      .LEN_W      (LEN_W)
    ) u_voice (
      .clk   (clk),
      .rst_n (rst_n),
      .step  (voice_step),
      .hit   (e_hit_r[v]),
      .slot  (e_slot_r[v]),
      .len   (e_len_r[v]),
      .play  (lane_play[v]),
      .addr  (lane_addr[v])
    );
  end

  // Saturate long lengths to the slot depth.
  assign len_sat = (m_llen_r > LLEN_W'(SLOT_DEPTH)) ? LEN_W'(SLOT_DEPTH) : LEN_W'(m_llen_r);

  // Slot length table: written by length loads, read per lane with registered data.
  // A load always leaves the match stage before a later tick reads the table.
  always_ff @(posedge clk) begin
    if (m_move && m_cmd_r == CMD_WR_LENGTH && m_lslot_r < SLOT_W'(NUM_SLOTS)) begin
      slot_len_mem[m_lslot_r[SIDX_W-1:0]] <= len_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (m_move) begin
      e_cmd_r     <= m_cmd_r;
      e_lslot_r   <= m_lslot_r;
      e_laddr_r   <= m_laddr_r;
      e_lsample_r <= m_lsample_r;
      for (int v = 0; v < NUM_VOICES; v++) begin
        e_hit_r[v]  <= lane_hit[v];
        e_slot_r[v] <= lane_slot[v];
        e_len_r[v]  <= slot_len_mem[lane_slot[v][SIDX_W-1:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r <= 1'b0;
    end else if (e_free) begin
      e_v_r <= m_v_r;
    end
  end

  // Sample writes: drop out-of-range slots and addresses.
  always_comb begin
    e_wen   = (e_cmd_r == CMD_WR_SAMPLE) && (e_lslot_r < SLOT_W'(NUM_SLOTS)) &&
              ({1'b0, e_laddr_r} < (LADDR_W+1)'(SLOT_DEPTH));
    e_waddr = ADDR_W'(e_lslot_r) * ADDR_W'(SLOT_DEPTH) + ADDR_W'(e_laddr_r);
    e_wext  = {SAMPLE_BITS'(0), e_lsample_r};
  end

  always_ff @(posedge clk) begin
    if (e_move) begin
      s_tick_r  <= (e_cmd_r == CMD_TICK);
      s_wen_r   <= e_wen;
      s_waddr_r <= e_waddr;
      s_wdata_r <= e_wext[SAMPLE_BITS-1:0];
      for (int v = 0; v < NUM_VOICES; v++) begin
        s_play_r[v] <= lane_play[v];
        s_addr_r[v] <= lane_addr[v];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_v_r  <= 1'b0;
      s_ph_r <= '0;
    end else begin
      if (s_free) begin
        s_v_r <= e_v_r;
      end
      // advance the lane phase on each read, wrap when the tick is done
      if (mem_ctl.re) begin
        s_ph_r <= s_done ? '0 : s_ph_r + LANE_W'(1);
      end
    end
  end

  // Memory port: reads for the current lane of a tick, else a sample write.
  always_comb begin
    mem_ctl.we   = s_v_r && !s_tick_r && s_wen_r;
    mem_ctl.re   = s_v_r && s_tick_r && rd_free;
    mem_ctl.lane = s_ph_r;
    mem_ctl.play = s_play_r[s_ph_r];
    mem_addr     = s_tick_r ? s_addr_r[s_ph_r] : s_waddr_r;
  end

  cvtsp_store #(
    .DEPTH       (DEPTH),
    .ADDR_W      (ADDR_W),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (mem_ctl),
    .addr       (mem_addr),
    .wdata      (s_wdata_r),
    .rd_free    (rd_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== tb/sv/cv_triggered_sample_player_unit_tb.sv =====
// Self-checking testbench for the two-voice triggered sample player.
// Depends on cvtsp_pkg and cv_triggered_sample_player_unit; drives load and tick words,
// predicts each tick's audio pair and checks it against the output stream.
module cv_triggered_sample_player_unit_tb;
  import cvtsp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_SLOTS     = 12;
  localparam int DEPTH       = 65536;
  localparam int N_VOICES    = 2;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 32;

  // The unused command code; the block must swallow it silently.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // One input word, split into its fields.
  typedef struct {
    logic [CMD_W-1:0]            cmd;
    logic signed [CV_W-1:0]      cv_a;
    logic signed [CV_W-1:0]      cv_b;
    logic [SLOT_W-1:0]           slot;
    logic [LADDR_W-1:0]          addr;
    logic signed [LSAMPLE_W-1:0] sample;
    logic [LLEN_W-1:0]           len;
  } player_word_t;

  // One tick's audio pair.
  typedef struct {
    logic [AUDIO_W-1:0] audio_a;
    logic [AUDIO_W-1:0] audio_b;
  } audio_pair_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [CMD_W-1:0]       in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // Predicted state of the player: written sample words, slot lengths, and the
  // read pointer and active slot of each voice.
  logic [AUDIO_W-1:0] sample_mem [int];
  logic [LLEN_W-1:0]  slot_len   [N_SLOTS];
  bit                 len_known  [N_SLOTS];
  logic [LLEN_W-1:0]  rd_ptr     [N_VOICES];
  logic [SLOT_W-1:0]  cur_slot   [N_VOICES];

  audio_pair_t audio_due[$];   // audio pairs still owed by the block, oldest first
  int          fault_count = 0;
  int          cycle_count = 0;

  // Knobs shared between the stimulus and the receiver.
  int          gap_odds = 0;        // percent chance of a sender gap before a word
  bit          calm = 1'b0;         // no idling on either side
  bit          long_hold_req = 1'b0;
  logic signed [CV_W-1:0] held_cv [N_VOICES];

  cv_triggered_sample_player_unit #(
    .NUM_SLOTS  (N_SLOTS),
    .SLOT_DEPTH (DEPTH),
    .SAMPLE_BITS(16)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #5 clk = ~clk;

  // Hard stop: a correct run finishes far below this.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("cv_triggered_sample_player_unit test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Lowest note window holding the voltage, or NO_SLOT when none does.
  function automatic int note_slot(logic signed [CV_W-1:0] cv);
    for (int i = 0; i < N_SLOTS; i++) begin
      if (int'(cv) >= int'(NOTE_CENTRE[i]) - int'(CV_WINDOW) &&
          int'(cv) <= int'(NOTE_CENTRE[i]) + int'(CV_WINDOW))
        return i;
    end
    return int'(NO_SLOT);
  endfunction

  // Advance one voice by one tick and return its audio word.
  function automatic logic [AUDIO_W-1:0] play_voice(int v, logic signed [CV_W-1:0] cv);
    int s;
    logic [LLEN_W-1:0] p;
    logic [AUDIO_W-1:0] word;
    s = note_slot(cv);
    if (s == int'(NO_SLOT)) begin
      // Drop the note: forget the slot and rewind.
      rd_ptr[v] = '0;
      cur_slot[v] = NO_SLOT;
      return '0;
    end
    if (cur_slot[v] != s[SLOT_W-1:0]) begin
      // A new note restarts the sample from its first word.
      cur_slot[v] = s[SLOT_W-1:0];
      rd_ptr[v] = '0;
    end
    p = rd_ptr[v];
    if (p >= slot_len[s]) return '0;
    word = sample_mem[s * DEPTH + int'(p)];
    rd_ptr[v] = p + 1'b1;
    return word;
  endfunction

  // Apply one accepted word to the predicted state.
  function automatic void predict_word(player_word_t w);
    audio_pair_t pair;
    logic [LLEN_W-1:0] clipped;
    case (w.cmd)
      CMD_TICK: begin
        pair.audio_a = play_voice(0, w.cv_a);
        pair.audio_b = play_voice(1, w.cv_b);
        audio_due.push_back(pair);
      end
      CMD_WR_SAMPLE: begin
        // Slots past the table are ignored; every 16-bit address is in range.
        if (w.slot < N_SLOTS) sample_mem[int'(w.slot) * DEPTH + int'(w.addr)] = w.sample;
      end
      CMD_WR_LENGTH: begin
        clipped = (w.len > DEPTH) ? LLEN_W'(DEPTH) : w.len;
        if (w.slot < N_SLOTS) begin
          slot_len[w.slot] = clipped;
          len_known[w.slot] = 1'b1;
        end
      end
      default: ;  // unused command: no state change, no result
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // Fill every field with random bits; callers overwrite what the command uses.
  function automatic player_word_t random_word(logic [CMD_W-1:0] cmd);
    player_word_t w;
    w.cmd    = cmd;
    w.cv_a   = CV_W'($urandom);
    w.cv_b   = CV_W'($urandom);
    w.slot   = SLOT_W'($urandom);
    w.addr   = LADDR_W'($urandom);
    w.sample = LSAMPLE_W'($urandom);
    w.len    = LLEN_W'($urandom);
    return w;
  endfunction

  // Offer one word, hold it until the handshake, then predict its effect.
  task automatic send_word(player_word_t w);
    int gap;
    if (!calm && gap_odds > 0 && $urandom_range(0, 99) < gap_odds) begin
      gap = $urandom_range(1, 15);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= w.cmd;
    in_tdata  <= {3'b000, w.len, w.sample, w.addr, w.slot, w.cv_b, w.cv_a};
    do @(posedge clk); while (!in_tready);
    predict_word(w);
  endtask

  task automatic write_length(int slot, logic [LLEN_W-1:0] len);
    player_word_t w;
    w = random_word(CMD_WR_LENGTH);
    w.slot = slot[SLOT_W-1:0];
    w.len = len;
    send_word(w);
  endtask

  task automatic write_sample(int slot, logic [LADDR_W-1:0] addr,
                              logic [LSAMPLE_W-1:0] sample);
    player_word_t w;
    w = random_word(CMD_WR_SAMPLE);
    w.slot = slot[SLOT_W-1:0];
    w.addr = addr;
    w.sample = sample;
    send_word(w);
  endtask

  // Send a tick. Before it, load any slot length or sample word the tick would
  // read that was never written, so no voice ever plays an undefined entry.
  task automatic tick_voices(logic signed [CV_W-1:0] cv_a, logic signed [CV_W-1:0] cv_b);
    player_word_t w;
    logic signed [CV_W-1:0] cv;
    logic [LLEN_W-1:0] p;
    int s;
    for (int v = 0; v < N_VOICES; v++) begin
      cv = (v == 0) ? cv_a : cv_b;
      s = note_slot(cv);
      if (s != int'(NO_SLOT)) begin
        if (!len_known[s]) write_length(s, LLEN_W'($urandom_range(0, 24)));
        p = (cur_slot[v] == s[SLOT_W-1:0]) ? rd_ptr[v] : '0;
        if (p < slot_len[s] && !sample_mem.exists(s * DEPTH + int'(p)))
          write_sample(s, p[LADDR_W-1:0], LSAMPLE_W'($urandom));
      end
    end
    w = random_word(CMD_TICK);
    w.cv_a = cv_a;
    w.cv_b = cv_b;
    send_word(w);
  endtask

  // Voltage for a held note: usually inside a window, sometimes just off it.
  function automatic logic signed [CV_W-1:0] note_cv();
    int centre;
    int offset;
    centre = int'(NOTE_CENTRE[$urandom_range(0, N_SLOTS - 1)]);
    if ($urandom_range(0, 9) == 0) begin
      offset = int'($urandom_range(83, 300));
      if ($urandom_range(0, 1)) offset = -offset;
    end else begin
      offset = int'($urandom_range(0, 164)) - 82;
    end
    return CV_W'(centre + offset);
  endfunction

  // Hold the input idle until every owed audio pair has come out.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (audio_due.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  always begin
    @(posedge clk);
    if (long_hold_req) begin
      // Hold off long enough for the block to fill and stall its input.
      long_hold_req = 1'b0;
      out_tready <= 1'b0;
      repeat (HOLD_CYCLES) @(posedge clk);
      out_tready <= 1'b1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      out_tready <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
      out_tready <= 1'b1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: compare each accepted result word with the oldest owed pair
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    audio_pair_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (audio_due.size() == 0) begin
        $error("result word %h with no tick outstanding", out_tdata);
        fault_count++;
      end else begin
        want = audio_due.pop_front();
        if (out_tdata[15:0] !== want.audio_a) begin
          $error("audio_a mismatch: expected %h, got %h", want.audio_a, out_tdata[15:0]);
          fault_count++;
        end
        if (out_tdata[31:16] !== want.audio_b) begin
          $error("audio_b mismatch: expected %h, got %h", want.audio_b, out_tdata[31:16]);
          fault_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Length and sample loads: sample extremes, zero length, saturated length,
  // slots past the table, the top address and the unused command.
  task automatic test_load_paths();
    player_word_t w;
    write_length(0, 17'd4);
    write_sample(0, 16'd0, 16'h8000);
    write_sample(0, 16'd1, 16'h7FFF);
    write_sample(0, 16'd2, 16'hFFFF);
    write_sample(0, 16'd3, 16'h0001);
    write_length(5, 17'd0);
    write_length(3, 17'h1FFFF);           // clipped to the slot depth
    write_length(12, 17'd7);              // slot past the table: ignored
    write_sample(15, 16'd0, 16'h1234);    // slot past the table: ignored
    write_sample(3, 16'hFFFF, 16'h5A5A);  // top address of a slot
    w = random_word(CMD_UNUSED);
    send_word(w);
  endtask

  // Window edges on both sides, voltages far out, and a centre past the table.
  task automatic test_note_windows();
    tick_voices(16'sd246, 16'sd245);
    tick_voices(16'sd410, 16'sd411);
    tick_voices(16'sd4178, 16'sd4179);
    tick_voices(-16'sd32768, 16'sd32767);
    tick_voices(16'sd0, 16'sd5120);
  endtask

  // Play through a slot and past its end, drop the note, restart, switch slots,
  // and hold a slot with zero length.
  task automatic test_voice_restart();
    repeat (5) tick_voices(16'sd328, 16'sd2048);
    tick_voices(-16'sd100, 16'sd2048);
    tick_voices(16'sd328, 16'sd1352);
    tick_voices(16'sd410, 16'sd1352);
    tick_voices(16'sd696, 16'sd1300);
    tick_voices(16'sd328, 16'sd4096);
  endtask

  // Stall the output for a long stretch while ticks and the loads they need keep coming back to back.
  task automatic test_backpressure();
    gap_odds = 0;
    long_hold_req = 1'b1;
    for (int i = 0; i < 40; i++) begin
      if ($urandom_range(0, 5) == 0) held_cv[0] = note_cv();
      if ($urandom_range(0, 5) == 0) held_cv[1] = note_cv();
      tick_voices(held_cv[0], held_cv[1]);
    end
    // Pause the sender until everything owed has come out.
    wait_drained();
  endtask

  // Mostly held notes with random content, plus loads, noise ticks and the
  // unused command.
  task automatic test_random_mix(int count);
    player_word_t w;
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        w = random_word(CMD_WR_LENGTH);
        w.slot = ($urandom_range(0, 9) == 0) ? SLOT_W'($urandom_range(12, 15))
                                             : SLOT_W'($urandom_range(0, N_SLOTS - 1));
        case ($urandom_range(0, 9))
          0, 1:    w.len = LLEN_W'($urandom);
          2:       w.len = LLEN_W'(DEPTH);
          default: w.len = LLEN_W'($urandom_range(0, 24));
        endcase
        send_word(w);
      end else if (pick < 22) begin
        w = random_word(CMD_WR_SAMPLE);
        if ($urandom_range(0, 9) != 0) w.slot = SLOT_W'($urandom_range(0, N_SLOTS - 1));
        if ($urandom_range(0, 4) != 0) w.addr = LADDR_W'($urandom_range(0, 31));
        send_word(w);
      end else if (pick < 25) begin
        w = random_word(CMD_UNUSED);
        send_word(w);
      end else if (pick < 35) begin
        tick_voices(CV_W'($urandom), CV_W'($urandom));
      end else begin
        if ($urandom_range(0, 5) == 0) held_cv[0] = note_cv();
        if ($urandom_range(0, 5) == 0) held_cv[1] = note_cv();
        tick_voices(held_cv[0], held_cv[1]);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    for (int v = 0; v < N_VOICES; v++) begin
      rd_ptr[v] = '0;
      cur_slot[v] = NO_SLOT;
      held_cv[v] = '0;
    end
    foreach (len_known[i]) begin
      len_known[i] = 1'b0;
      slot_len[i] = '0;
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    gap_odds = 20;
    test_load_paths();
    test_note_windows();
    test_voice_restart();
    test_backpressure();

    gap_odds = 20;
    test_random_mix(330);
    // Final stretch with neither side idling.
    calm = 1'b1;
    test_random_mix(60);

    wait_drained();
    // Allow any stray result to surface before judging.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fault_count == 0 && audio_due.size() == 0) begin
      $display("cv_triggered_sample_player_unit test passed");
    end else begin
      $display("cv_triggered_sample_player_unit test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/cvtsp_pkg.sv
rtl/cvtsp_match.sv
rtl/cvtsp_voice.sv
rtl/cvtsp_store.sv
rtl/cv_triggered_sample_player_unit.sv
tb/sv/cv_triggered_sample_player_unit_tb.sv
